FILE: src/mrq_pkg.sv
// Package for the mutual exclusion request queue node.
// Holds field widths, message kind codes, register indexes, FSM states and
// the command/status structs shared by the controller and the datapath.
`default_nettype none

package mrq_pkg;

  // Field widths fixed by the message and result formats.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SENDER_W = 4;
  localparam int unsigned PREV_W   = 5;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // Default number of queue slots and waiting marks.
  localparam int unsigned NODES_DEF = 16;

  // Reset values of the configuration registers.
  localparam logic [ID_W-1:0]  MY_ID_RST      = '0;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(16);

  // Message kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_INVALID = 2'd0,
    KIND_REQ     = 2'd1,
    KIND_ACC     = 2'd2,
    KIND_REL     = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MY_ID      = 1'b0,
    REG_NODE_COUNT = 1'b1
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the input item, update clock, holder, count, queue write
    logic scan_rd;  // read the next queue slot
    logic finish;   // commit the decision and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_scan;  // offered item is a request or a release
    logic scan_last;   // scan address is at the last slot
    logic out_free;    // result register can take a new item
  } sts_t;

endpackage

`default_nettype wire

FILE: src/mrq_if.sv
// Handshake channels of the request queue node: the message input channel
// and the result output channel. Depends on mrq_pkg for field widths.
`default_nettype none

interface mrq_msg_if import mrq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          msg_kind;
  logic [STAMP_W-1:0]         msg_stamp;
  logic [SENDER_W-1:0]        msg_sender;
  logic signed [PREV_W-1:0]   msg_prev;

  modport source (output valid, msg_kind, msg_stamp, msg_sender, msg_prev, input ready);
  modport sink   (input valid, msg_kind, msg_stamp, msg_sender, msg_prev, output ready);
endinterface

interface mrq_res_if import mrq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       send_accept;
  logic [SENDER_W-1:0]        accept_dest;
  logic [STAMP_W-1:0]         accept_stamp;
  logic signed [PREV_W-1:0]   accept_prev;
  logic                       ready_to_enter;
  logic [CNT_W-1:0]           accept_total;
  logic                       bad_type;

  modport source (output valid, send_accept, accept_dest, accept_stamp, accept_prev,
                  ready_to_enter, accept_total, bad_type, input ready);
  modport sink   (input valid, send_accept, accept_dest, accept_stamp, accept_prev,
                  ready_to_enter, accept_total, bad_type, output ready);
endinterface

`default_nettype wire

FILE: src/mutex_request_queue_node.sv
// Request queue node: a request or release passes from accept through one capture
// step, NODES single-port queue reads, one drain step and one commit step; an accept
// or invalid message goes from capture straight to commit.
// The result appears in the output register the cycle after commit and may wait
// there while the next item is taken. Asynchronous active-low reset clears the
// queue, marks, clock and count, sets holder to -1, my_id to 0, node count to 16.
`default_nettype none

module mutex_request_queue_node import mrq_pkg::*; #(
  parameter int unsigned NODES = NODES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  mrq_msg_if.sink                   msg_i,
  mrq_res_if.source                 res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // Sequencer.
  mrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (msg_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign msg_i.ready = in_ready;

  // Queue, node state and result register.
  mrq_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .kind_i           (msg_i.msg_kind),
    .stamp_i          (msg_i.msg_stamp),
    .sender_i         (msg_i.msg_sender),
    .prev_i           (msg_i.msg_prev),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .res_ready_i      (res_o.ready),
    .res_valid_o      (res_o.valid),
    .send_accept_o    (res_o.send_accept),
    .accept_dest_o    (res_o.accept_dest),
    .accept_stamp_o   (res_o.accept_stamp),
    .accept_prev_o    (res_o.accept_prev),
    .ready_to_enter_o (res_o.ready_to_enter),
    .accept_total_o   (res_o.accept_total),
    .bad_type_o       (res_o.bad_type)
  );

  // A committed item shows up as a valid result in the next cycle.
  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> res_o.valid)
    else $error("committed item did not reach the result register");

  // Once an item is taken the block is busy in the next cycle.
  a_busy_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !msg_i.ready)
    else $error("input ready right after an item was taken");

  // An unknown message kind never causes an accept to be sent.
  a_bad_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.bad_type) |-> !res_o.send_accept)
    else $error("accept sent for an unknown message kind");

  // The commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.finish && res_o.valid) |-> res_o.ready)
    else $error("result register overwritten while still held");

endmodule

`default_nettype wire

FILE: src/mrq_ctrl.sv
// Controller of the request queue node: sequences capture, queue scan and
// result commit. Depends on mrq_pkg for states and command/status structs.
`default_nettype none

module mrq_ctrl import mrq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.needs_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last read is folded into the head search in this cycle.
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/mrq_datapath.sv
// Datapath of the request queue node: configuration registers, queue memory
// with valid bits, waiting marks, head search, clock, holder, accept count and
// the result register. Depends on mrq_pkg.
`default_nettype none

module mrq_datapath import mrq_pkg::*; #(
  parameter int unsigned NODES = NODES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration writes
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  // Offered input item
  input  wire logic [KIND_W-1:0]        kind_i,
  input  wire logic [STAMP_W-1:0]       stamp_i,
  input  wire logic [SENDER_W-1:0]      sender_i,
  input  wire logic signed [PREV_W-1:0] prev_i,
  // Controller link
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  // Result item
  input  wire logic                     res_ready_i,
  output logic                          res_valid_o,
  output logic                          send_accept_o,
  output logic [SENDER_W-1:0]           accept_dest_o,
  output logic [STAMP_W-1:0]            accept_stamp_o,
  output logic signed [PREV_W-1:0]      accept_prev_o,
  output logic                          ready_to_enter_o,
  output logic [CNT_W-1:0]              accept_total_o,
  output logic                          bad_type_o
);

  localparam int unsigned IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EXT_W   = SENDER_W + IDX_W;
  localparam int unsigned ENTRY_W = STAMP_W + SENDER_W;

  // Configuration registers.
  logic [ID_W-1:0]  my_id_q;
  logic [CNT_W-1:0] node_count_q;

  // Queue storage and marks.
  logic [ENTRY_W-1:0] mem_q [NODES];
  logic [NODES-1:0]   valid_q;
  logic [NODES-1:0]   waiting_q;

  // Node state.
  logic [STAMP_W-1:0]       clock_q;
  logic signed [PREV_W-1:0] holder_q;
  logic [CNT_W-1:0]         count_q;

  // Item held while it is worked on.
  kind_e               kind_q;
  logic [SENDER_W-1:0] sender_q;

  // Scan pipeline and running head.
  logic [IDX_W-1:0]    addr_q;
  logic                rd_vld_q;
  logic                rd_valid_q;
  logic [IDX_W-1:0]    rd_addr_q;
  logic [ENTRY_W-1:0]  rd_data_q;
  logic                removed_q;
  logic                best_valid_q;
  logic [STAMP_W-1:0]  best_stamp_q;
  logic [SENDER_W-1:0] best_sender_q;

  // Result register.
  logic                     res_valid_q;
  logic                     send_accept_q;
  logic [SENDER_W-1:0]      accept_dest_q;
  logic [STAMP_W-1:0]       accept_stamp_q;
  logic signed [PREV_W-1:0] accept_prev_q;
  logic                     ready_to_enter_q;
  logic [CNT_W-1:0]         accept_total_q;
  logic                     bad_type_q;

  kind_e               kind_in;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic [STAMP_W-1:0]  rd_stamp;
  logic [SENDER_W-1:0] rd_sender;
  logic                rd_hit;
  logic                rd_better;
  logic [EXT_W-1:0]    snd_ext;
  logic [EXT_W-1:0]    best_ext;
  logic                snd_in_range;
  logic                best_in_range;
  logic [IDX_W-1:0]    snd_idx;
  logic [IDX_W-1:0]    best_idx;
  logic                emit;
  logic [SENDER_W-1:0] emit_dest;
  logic                set_wait;
  logic                clr_wait;
  logic [STAMP_W-1:0]  clock_inc;
  logic                head_mine;

  assign kind_in = kind_e'(kind_i);

  // Lowest free queue slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Entry returned by the scan read and its role in the head search.
  assign rd_stamp  = rd_data_q[ENTRY_W-1:SENDER_W];
  assign rd_sender = rd_data_q[SENDER_W-1:0];
  assign rd_hit    = (kind_q == KIND_REL) && !removed_q && rd_valid_q &&
                     (rd_sender == sender_q);
  assign rd_better = !best_valid_q || (rd_stamp < best_stamp_q) ||
                     ((rd_stamp == best_stamp_q) && (rd_sender < best_sender_q));

  // Sender indexes into the waiting marks, with their range checks.
  assign snd_ext       = {{IDX_W{1'b0}}, sender_q};
  assign best_ext      = {{IDX_W{1'b0}}, best_sender_q};
  assign snd_in_range  = snd_ext < EXT_W'(NODES);
  assign best_in_range = best_ext < EXT_W'(NODES);
  assign snd_idx       = snd_ext[IDX_W-1:0];
  assign best_idx      = best_ext[IDX_W-1:0];

  // Decision taken when the item is committed.
  always_comb begin
    emit      = 1'b0;
    emit_dest = '0;
    set_wait  = 1'b0;
    clr_wait  = 1'b0;
    case (kind_q)
      KIND_REQ: begin
        if (best_valid_q && (best_sender_q == sender_q)) begin
          emit      = 1'b1;
          emit_dest = sender_q;
        end else begin
          set_wait = snd_in_range;
        end
      end
      KIND_REL: begin
        if (best_valid_q && best_in_range && waiting_q[best_idx]) begin
          emit      = 1'b1;
          emit_dest = best_sender_q;
          clr_wait  = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign clock_inc = (clock_q != '1) ? clock_q + STAMP_W'(1) : clock_q;
  assign head_mine = best_valid_q && (best_sender_q == SENDER_W'(my_id_q));

  // Queue memory: written on a request, read one slot per scan cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && (kind_in == KIND_REQ) && free_found) begin
      mem_q[free_idx] <= {stamp_i, sender_i};
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q      <= MY_ID_RST;
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MY_ID:      my_id_q      <= cfg_data_i[ID_W-1:0];
        REG_NODE_COUNT: node_count_q <= cfg_data_i[CNT_W-1:0];
        default:        my_id_q      <= my_id_q;
      endcase
    end
  end

  // Node state, queue control and head search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      waiting_q     <= '0;
      clock_q       <= '0;
      holder_q      <= '1;
      count_q       <= '0;
      kind_q        <= KIND_INVALID;
      sender_q      <= '0;
      addr_q        <= '0;
      rd_vld_q      <= 1'b0;
      rd_valid_q    <= 1'b0;
      rd_addr_q     <= '0;
      removed_q     <= 1'b0;
      best_valid_q  <= 1'b0;
      best_stamp_q  <= '0;
      best_sender_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;

      // Take the item: clock and holder follow the message, accepts count.
      if (cmd_i.capture) begin
        kind_q   <= kind_in;
        sender_q <= sender_i;
        if (stamp_i > clock_q) begin
          clock_q <= stamp_i;
        end
        if (prev_i > holder_q) begin
          holder_q <= prev_i;
        end
        if ((kind_in == KIND_ACC) && (count_q < node_count_q)) begin
          count_q <= count_q + CNT_W'(1);
        end
        if ((kind_in == KIND_REQ) && free_found) begin
          valid_q[free_idx] <= 1'b1;
        end
        if ((kind_in == KIND_REQ) || (kind_in == KIND_REL)) begin
          addr_q       <= '0;
          removed_q    <= 1'b0;
          best_valid_q <= 1'b0;
        end
      end

      // Issue one slot read per cycle.
      if (cmd_i.scan_rd) begin
        rd_valid_q <= valid_q[addr_q];
        rd_addr_q  <= addr_q;
        addr_q     <= addr_q + IDX_W'(1);
      end

      // A release drops the sender's lowest slot; every other live slot
      // competes for the head.
      if (rd_vld_q) begin
        if (rd_hit) begin
          valid_q[rd_addr_q] <= 1'b0;
          removed_q          <= 1'b1;
        end else if (rd_valid_q && rd_better) begin
          best_valid_q  <= 1'b1;
          best_stamp_q  <= rd_stamp;
          best_sender_q <= rd_sender;
        end
      end

      // Commit: sending an accept ticks the clock.
      if (cmd_i.finish) begin
        if (emit) begin
          clock_q <= clock_inc;
        end
        if (set_wait) begin
          waiting_q[snd_idx] <= 1'b1;
        end
        if (clr_wait) begin
          waiting_q[best_idx] <= 1'b0;
        end
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      send_accept_q    <= emit;
      accept_dest_q    <= emit ? emit_dest : '0;
      accept_stamp_q   <= emit ? clock_inc : '0;
      accept_prev_q    <= emit ? holder_q : '0;
      ready_to_enter_q <= (count_q == node_count_q) && head_mine;
      accept_total_q   <= count_q;
      bad_type_q       <= (kind_q == KIND_INVALID);
    end
  end

  assign sts_o.needs_scan = (kind_in == KIND_REQ) || (kind_in == KIND_REL);
  assign sts_o.scan_last  = (addr_q == IDX_W'(NODES - 1));
  assign sts_o.out_free   = !res_valid_q || res_ready_i;

  assign res_valid_o      = res_valid_q;
  assign send_accept_o    = send_accept_q;
  assign accept_dest_o    = accept_dest_q;
  assign accept_stamp_o   = accept_stamp_q;
  assign accept_prev_o    = accept_prev_q;
  assign ready_to_enter_o = ready_to_enter_q;
  assign accept_total_o   = accept_total_q;
  assign bad_type_o       = bad_type_q;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the mutex request queue node: drives request, accept,
// release and unknown-kind items, predicts every result and checks it field by field.
// Depends on mrq_pkg, on the channel interfaces in mrq_if.sv and on the node itself.

module tb_top;
  import mrq_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  // Expected content of one result item.
  typedef struct {
    bit                        send_accept;
    bit [SENDER_W-1:0]         accept_dest;
    bit [STAMP_W-1:0]          accept_stamp;
    bit signed [PREV_W-1:0]    accept_prev;
    bit                        ready_to_enter;
    bit [CNT_W-1:0]            accept_total;
    bit                        bad_type;
  } node_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  mrq_msg_if msg_ch ();
  mrq_res_if res_ch ();

  mutex_request_queue_node dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .msg_i      (msg_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the node: request queue, waiting marks, clock, holder and count.
  bit                     queued_valid [NODES_DEF];
  bit [STAMP_W-1:0]       queued_stamp [NODES_DEF];
  bit [SENDER_W-1:0]      queued_from  [NODES_DEF];
  bit                     waiting_mark [NODES_DEF];
  bit [STAMP_W-1:0]       logical_clock;
  bit signed [PREV_W-1:0] known_holder;
  bit [CNT_W-1:0]         accepts_seen;
  bit [ID_W-1:0]          my_index;
  bit [CNT_W-1:0]         quorum;

  node_result_t pending_results [$];

  int errors         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int kinds_sent [4];
  int accepts_due    = 0;
  int ready_results  = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow state after reset.
  task automatic reset_model();
    for (int i = 0; i < NODES_DEF; i++) begin
      queued_valid[i] = 1'b0;
      queued_stamp[i] = '0;
      queued_from[i]  = '0;
      waiting_mark[i] = 1'b0;
    end
    logical_clock = '0;
    known_holder  = -1;
    accepts_seen  = '0;
    my_index      = MY_ID_RST;
    quorum        = NODE_COUNT_RST;
  endtask

  // Slot of the queue head, ordered by stamp and then sender; -1 when empty.
  function automatic int queue_head();
    int best = -1;
    for (int i = 0; i < NODES_DEF; i++) begin
      if (queued_valid[i] && (best < 0 || queued_stamp[i] < queued_stamp[best] ||
          (queued_stamp[i] == queued_stamp[best] && queued_from[i] < queued_from[best])))
        best = i;
    end
    return best;
  endfunction

  // Sending an accept bumps the clock, which sticks at its maximum.
  function automatic node_result_t with_accept(node_result_t r, bit [SENDER_W-1:0] dest);
    if (logical_clock != '1)
      logical_clock++;
    r.send_accept  = 1'b1;
    r.accept_dest  = dest;
    r.accept_stamp = logical_clock;
    r.accept_prev  = known_holder;
    return r;
  endfunction

  // Apply one message item to the shadow state and return the result it causes.
  function automatic node_result_t predict_node_step(kind_e kind, bit [STAMP_W-1:0] stamp,
                                                     bit [SENDER_W-1:0] sender,
                                                     bit signed [PREV_W-1:0] prev);
    node_result_t r;
    int head;
    bit done;
    r.send_accept  = 1'b0;
    r.accept_dest  = '0;
    r.accept_stamp = '0;
    r.accept_prev  = '0;
    r.bad_type     = 1'b0;
    done           = 1'b0;

    if (stamp > logical_clock)
      logical_clock = stamp;
    if (prev > known_holder)
      known_holder = prev;

    case (kind)
      KIND_ACC: begin
        if (accepts_seen < quorum)
          accepts_seen++;
      end
      KIND_REQ: begin
        // A full queue drops the entry; the head test still runs.
        for (int i = 0; i < NODES_DEF; i++) begin
          if (!done && !queued_valid[i]) begin
            queued_valid[i] = 1'b1;
            queued_stamp[i] = stamp;
            queued_from[i]  = sender;
            done = 1'b1;
          end
        end
        head = queue_head();
        if (head >= 0 && queued_from[head] == sender)
          r = with_accept(r, sender);
        else
          waiting_mark[sender] = 1'b1;
      end
      KIND_REL: begin
        // Only the lowest slot held by the sender is freed.
        for (int i = 0; i < NODES_DEF; i++) begin
          if (!done && queued_valid[i] && queued_from[i] == sender) begin
            queued_valid[i] = 1'b0;
            done = 1'b1;
          end
        end
        head = queue_head();
        if (head >= 0 && waiting_mark[queued_from[head]]) begin
          waiting_mark[queued_from[head]] = 1'b0;
          r = with_accept(r, queued_from[head]);
        end
      end
      default: begin
        r.bad_type = 1'b1;
      end
    endcase

    head = queue_head();
    r.ready_to_enter = (accepts_seen == quorum) && (head >= 0) &&
                       (queued_from[head] == my_index);
    r.accept_total = accepts_seen;
    return r;
  endfunction

  // Offer one message item, with random idle cycles first, and record its result.
  task automatic send_msg(kind_e kind, bit [STAMP_W-1:0] stamp, bit [SENDER_W-1:0] sender,
                          bit signed [PREV_W-1:0] prev);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_ch.valid      <= 1'b1;
    msg_ch.msg_kind   <= kind;
    msg_ch.msg_stamp  <= stamp;
    msg_ch.msg_sender <= sender;
    msg_ch.msg_prev   <= prev;
    do @(posedge clk_i); while (msg_ch.ready !== 1'b1);
    kinds_sent[kind]++;
    pending_results.push_back(predict_node_step(kind, stamp, sender, prev));
  endtask

  // Stop offering items until every expected result has arrived, then let the node settle.
  task automatic wait_for_drain();
    @(negedge clk_i);
    msg_ch.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk_i);
    repeat (NODES_DEF + 4) @(negedge clk_i);
  endtask

  // One register write on the configuration port.
  task automatic write_reg(cfg_reg_e idx, bit [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_MY_ID)
      my_index = data[ID_W-1:0];
    else
      quorum = data;
  endtask

  task automatic set_node_config(bit [ID_W-1:0] id, bit [CNT_W-1:0] count);
    wait_for_drain();
    write_reg(REG_MY_ID, CFG_W'(id));
    write_reg(REG_NODE_COUNT, count);
  endtask

  // Mostly well-formed traffic: releases target queued senders, stamps track the clock
  // and often repeat queued stamps so that the sender tiebreak is exercised.
  task automatic send_random_msg(int fill_bias);
    int used [$];
    int pick;
    kind_e kind;
    bit [STAMP_W-1:0] stamp;
    bit [SENDER_W-1:0] sender;
    bit signed [PREV_W-1:0] prev;
    for (int i = 0; i < NODES_DEF; i++)
      if (queued_valid[i])
        used.push_back(i);

    pick = $urandom_range(0, 99);
    if (pick < 4)
      kind = KIND_INVALID;
    else if (pick < 30)
      kind = KIND_ACC;
    else if ($urandom_range(0, 16 + fill_bias) >= used.size())
      kind = KIND_REQ;
    else
      kind = KIND_REL;

    sender = ($urandom_range(0, 99) < 35) ? my_index : SENDER_W'($urandom_range(0, 15));
    if (kind == KIND_REL && used.size() > 0 && $urandom_range(0, 99) < 85)
      sender = queued_from[used[$urandom_range(0, used.size() - 1)]];

    pick = $urandom_range(0, 99);
    if (pick < 50)
      stamp = logical_clock + $urandom_range(0, 4);
    else if (pick < 78)
      stamp = logical_clock - $urandom_range(0, (logical_clock < 6) ? logical_clock : 6);
    else if (pick < 94 && used.size() > 0)
      stamp = queued_stamp[used[$urandom_range(0, used.size() - 1)]];
    else
      stamp = $urandom_range(0, logical_clock);

    // The holder only climbs, so raise it rarely to keep it moving through the run.
    if (known_holder < 15 && $urandom_range(0, 99) < 3)
      prev = known_holder + 1;
    else
      prev = PREV_W'(-16 + $urandom_range(0, known_holder + 16));

    send_msg(kind, stamp, sender, prev);
  endtask

  // Reset values: unknown kind and a release on the empty queue.
  task automatic test_reset_state();
    send_msg(KIND_INVALID, 32'd0, 4'd0, -16);
    send_msg(KIND_REL, 32'd2, 4'd15, -1);
  endtask

  // Zero accepts needed; fill the queue past full, with ties and repeated senders.
  task automatic test_queue_fill();
    set_node_config(4'd15, 5'd0);
    send_msg(KIND_REQ, 32'd9, 4'd15, 0);
    send_msg(KIND_REQ, 32'd9, 4'd4, -1);
    send_msg(KIND_REQ, 32'd12, 4'd3, -1);
    send_msg(KIND_REQ, 32'd12, 4'd3, -1);
    for (int i = 0; i < 12; i++)
      send_msg(KIND_REQ, 32'(20 + i), SENDER_W'(i), -1);
    // The queue is full now, so this entry is dropped.
    send_msg(KIND_REQ, 32'd1, 4'd1, -1);
    send_msg(KIND_REL, 32'd9, 4'd4, -1);
    send_msg(KIND_REL, 32'd9, 4'd15, -1);
  endtask

  // Accept counting saturates at the node count.
  task automatic test_accept_count();
    set_node_config(4'd0, 5'd1);
    send_msg(KIND_ACC, 32'd0, 4'd9, -1);
    send_msg(KIND_ACC, 32'd5, 4'd2, -1);
  endtask

  task automatic test_random_traffic(int items, int idle_pct, int stall_pct,
                                     bit [ID_W-1:0] id, bit [CNT_W-1:0] count, int fill_bias);
    set_node_config(id, count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      // Now and then hold off until the node has answered everything.
      if ($urandom_range(0, 99) == 0)
        wait_for_drain();
      send_random_msg(fill_bias);
    end
  endtask

  // Clock and holder driven to their maximum; accepts must keep the clock saturated.
  task automatic test_clock_saturation();
    bit has_room;
    set_node_config(4'd0, 5'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    has_room = 1'b0;
    for (int i = 0; i < NODES_DEF; i++)
      if (!queued_valid[i])
        has_room = 1'b1;
    if (!has_room)
      send_msg(KIND_REL, 32'd0, queued_from[0], -1);
    send_msg(KIND_INVALID, 32'hFFFF_FFFF, 4'd15, 15);
    send_msg(KIND_REQ, 32'd0, 4'd0, 15);
    send_msg(KIND_REL, 32'd0, 4'd0, 15);
    send_msg(KIND_ACC, 32'hFFFF_FFFF, 4'd7, 15);
  endtask

  // Receiver side: ready is redrawn every cycle.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string field, logic [STAMP_W-1:0] want,
                                      logic [STAMP_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Compare each result item with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    node_result_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with no expectation waiting", $time);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.send_accept)
          accepts_due++;
        if (want.ready_to_enter)
          ready_results++;
        check_field("send_accept", want.send_accept, res_ch.send_accept);
        check_field("accept_dest", want.accept_dest, res_ch.accept_dest);
        check_field("accept_stamp", want.accept_stamp, res_ch.accept_stamp);
        check_field("accept_prev", want.accept_prev, res_ch.accept_prev);
        check_field("ready_to_enter", want.ready_to_enter, res_ch.ready_to_enter);
        check_field("accept_total", want.accept_total, res_ch.accept_total);
        check_field("bad_type", want.bad_type, res_ch.bad_type);
      end
    end
  end

  // Watchdog: too many cycles in a row without any item moving ends the run.
  always @(posedge clk_i) begin
    if ((msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("mutex_request_queue_node: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    msg_ch.valid      = 1'b0;
    msg_ch.msg_kind   = KIND_INVALID;
    msg_ch.msg_stamp  = '0;
    msg_ch.msg_sender = '0;
    msg_ch.msg_prev   = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_MY_ID;
    cfg_data_i        = '0;
    rst_ni            = 1'b0;
    reset_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_queue_fill();
    test_accept_count();

    test_random_traffic(115, 0, 0, 4'd0, 5'd3, 0);
    test_random_traffic(115, 48, 0, 4'd15, 5'd5, 8);
    test_random_traffic(115, 0, 48, 4'd9, 5'd8, 2);
    test_random_traffic(115, 10, 10, ID_W'($urandom_range(0, 15)), 5'd12, 12);
    test_random_traffic(115, 0, 0, 4'd15, 5'd16, 4);
    test_random_traffic(115, 48, 0, ID_W'($urandom_range(0, 15)), 5'd16, 0);
    test_random_traffic(115, 0, 48, 4'd0, 5'd16, 10);
    test_random_traffic(115, 10, 10, ID_W'($urandom_range(0, 15)),
                        CNT_W'($urandom_range(1, 16)), 3);

    test_clock_saturation();

    wait_for_drain();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Sent %0d requests, %0d releases, %0d accepts and %0d items of unknown kind.",
             kinds_sent[KIND_REQ], kinds_sent[KIND_REL], kinds_sent[KIND_ACC],
             kinds_sent[KIND_INVALID]);
    $display("Checked %0d outgoing accepts and %0d ready results over several settings.",
             accepts_due, ready_results);
    if (errors == 0) begin
      $display("mutex_request_queue_node: match");
    end else begin
      $display("mutex_request_queue_node: mismatch");
    end
    $finish;
  end

endmodule

FILE: mutex_request_queue_node.f
src/mrq_pkg.sv
src/mrq_if.sv
src/mrq_ctrl.sv
src/mrq_datapath.sv
src/mutex_request_queue_node.sv
test/tb_top.sv
